>>> src/swm_pkg.sv
// Shared types and constants of the sliding window midpoint block.
`timescale 1ns / 1ps

package swm_pkg;

  // Width and reset value of the window length register
  localparam int unsigned CfgWidth = 9;
  localparam logic [CfgWidth-1:0] LenReset = 9'd14;

  // Width of one sample
  localparam int unsigned SampleWidth = 32;

  // One input item
  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          restart;
    logic                          last_sample;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic signed [SampleWidth:0] midpoint_x2;
    logic [31:0]                 position;
    logic                        final_res;
  } out_item_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift;  // take the left neighbor's sample
    logic run;    // advance the max/min partials one cell
    logic start;  // seed the partial at the window's oldest cell
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } seq_state_e;

endpackage

>>> src/swm_cell.sv
// One window cell: a sample stage plus a max/min partial handed to the next lower cell.
`timescale 1ns / 1ps

module swm_cell #(
  parameter int unsigned SampleWidth = 32,
  parameter int unsigned LenWidth    = 9,
  parameter int unsigned Idx         = 0
) (
  input  logic                          clk_i,
  input  swm_pkg::cell_ctrl_t           ctrl_i,
  input  logic [LenWidth-1:0]           len_i,
  input  logic signed [SampleWidth-1:0] smp_i,
  output logic signed [SampleWidth-1:0] smp_o,
  input  logic signed [SampleWidth-1:0] hi_i,
  input  logic signed [SampleWidth-1:0] lo_i,
  output logic signed [SampleWidth-1:0] hi_o,
  output logic signed [SampleWidth-1:0] lo_o
);

  logic signed [SampleWidth-1:0] smp_q, smp_d;
  logic signed [SampleWidth-1:0] hi_q, hi_d;
  logic signed [SampleWidth-1:0] lo_q, lo_d;
  logic                          oldest;

  // This cell holds the oldest sample of the window
  assign oldest = (len_i - LenWidth'(1)) == LenWidth'(Idx);

  // Shift the sample stage; seed or fold the partials
  always_comb begin
    smp_d = ctrl_i.shift ? smp_i : smp_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctrl_i.run) begin
      if (ctrl_i.start && oldest) begin
        hi_d = smp_q;
        lo_d = smp_q;
      end else begin
        hi_d = (hi_i > smp_q) ? hi_i : smp_q;
        lo_d = (lo_i < smp_q) ? lo_i : smp_q;
      end
    end
  end

  // Payload only: no reset needed
  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign smp_o = smp_q;
  assign hi_o  = hi_q;
  assign lo_o  = lo_q;

endmodule

>>> src/swm_seq.sv
// Sequencer: input handshake, series bookkeeping, sweep timing and result register.
`timescale 1ns / 1ps

module swm_seq #(
  parameter int unsigned WindowMax   = 256,
  parameter int unsigned LenWidth    = 9
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  swm_pkg::in_item_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output swm_pkg::out_item_t                     out_data_o,
  input  logic [swm_pkg::CfgWidth-1:0]           cfg_len_i,
  output swm_pkg::cell_ctrl_t                    ctrl_o,
  output logic [LenWidth-1:0]                    len_o,
  input  logic signed [swm_pkg::SampleWidth-1:0] hi_i,
  input  logic signed [swm_pkg::SampleWidth-1:0] lo_i
);

  swm_pkg::seq_state_e state_q, state_d;
  logic [LenWidth-1:0] fill_q, fill_d, fill_base;
  logic [LenWidth-1:0] cnt_q, cnt_d;
  logic [31:0]         idx_q, idx_d, idx_base;
  logic [31:0]         pos_q, pos_d;
  logic                last_q, last_d;
  logic                first_q, first_d;
  logic                out_valid_q, out_valid_d;
  swm_pkg::out_item_t  out_q, out_d;
  logic [LenWidth-1:0] eff_len;
  logic                accept, slot_free;
  logic signed [swm_pkg::SampleWidth:0] sum;

  // Clamp the configured length into 1..WindowMax
  always_comb begin
    if (cfg_len_i == '0) begin
      eff_len = LenWidth'(1);
    end else if (32'(cfg_len_i) > 32'(WindowMax)) begin
      eff_len = LenWidth'(WindowMax);
    end else begin
      eff_len = LenWidth'(cfg_len_i);
    end
  end

  assign len_o      = eff_len;
  assign in_ready_o = (state_q == swm_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // Exact sum of maximum and minimum
  assign sum = {hi_i[swm_pkg::SampleWidth-1], hi_i} + {lo_i[swm_pkg::SampleWidth-1], lo_i};

  // Series bookkeeping starts over on restart
  assign fill_base = in_data_i.restart ? '0 : fill_q;
  assign idx_base  = in_data_i.restart ? '0 : idx_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    last_d      = last_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctrl_o      = '0;
    unique case (state_q)
      swm_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl_o.shift = 1'b1;
          fill_d = (32'(fill_base) < 32'(WindowMax)) ? fill_base + LenWidth'(1) : fill_base;
          idx_d  = idx_base + 32'd1;
          pos_d  = idx_base;
          last_d = in_data_i.last_sample;
          cnt_d  = eff_len - LenWidth'(1);
          first_d = 1'b1;
          // Sweep only once a full window has been seen
          if (fill_d >= eff_len) begin
            state_d = swm_pkg::ST_SWEEP;
          end
        end
      end
      swm_pkg::ST_SWEEP: begin
        // Advance the partial one cell toward cell 0
        ctrl_o.run   = 1'b1;
        ctrl_o.start = first_q;
        first_d      = 1'b0;
        if (cnt_q == '0) begin
          state_d = swm_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q - LenWidth'(1);
        end
      end
      swm_pkg::ST_FINISH: begin
        // Hold until the result register frees up
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.position    = pos_q;
          out_d.final_res   = last_q;
          out_d.midpoint_x2 = sum;
          state_d = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> src/sliding_window_midpoint.sv
// Top level: moving-window maximum plus minimum over a chain of sample cells.
//
// Usage: one signed sample per input transfer (in_valid_i/in_ready_o with
// in_data_i); one result per output transfer (out_valid_o/out_ready_i with
// out_data_o). The window length register is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, as
// the block does not enforce this. 0 acts as 1, values above WindowMax
// act as WindowMax. Each accepted sample shifts into a chain of WindowMax
// cells. Until the series has seen a full window, a sample gives no result
// and the block is ready again in the next cycle. Otherwise a max/min
// partial is seeded at the window's oldest cell and walks one cell per
// cycle to cell 0; the result is registered in the finish state once the
// output register is free, and the next sample is taken only after that, so
// the block takes no new sample while one is in its sweep. The length of
// that walk sets the throughput.
// A result waits in the output register while the receiver stalls; the
// block still takes the next sample, and holds a new result until the
// register frees up.
// Reset empties the series, clears the output valid and sets the window
// length to 14; cell contents are undefined until written.
`timescale 1ns / 1ps

module sliding_window_midpoint #(
  parameter int unsigned WindowMax   = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  swm_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output swm_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [swm_pkg::CfgWidth-1:0] cfg_wdata_i
);

  localparam int unsigned LenWidth    = $clog2(WindowMax + 1);
  localparam int unsigned SampleWidth = swm_pkg::SampleWidth;

  logic [swm_pkg::CfgWidth-1:0] cfg_len_q;
  swm_pkg::cell_ctrl_t          ctrl;
  logic [LenWidth-1:0]          len;
  logic signed [SampleWidth-1:0] raw;
  logic signed [SampleWidth-1:0] smp [WindowMax];
  logic signed [SampleWidth-1:0] hi  [WindowMax];
  logic signed [SampleWidth-1:0] lo  [WindowMax];

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= swm_pkg::LenReset;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  // Take the sample field into the head of the chain
  assign raw = in_data_i.sample;

  swm_seq #(
    .WindowMax  (WindowMax),
    .LenWidth   (LenWidth)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_len_i  (cfg_len_q),
    .ctrl_o     (ctrl),
    .len_o      (len),
    .hi_i       (hi[0]),
    .lo_i       (lo[0])
  );

  // Cell chain: samples move up, partials move down
  for (genvar k = 0; k < WindowMax; k++) begin : g_cell
    logic signed [SampleWidth-1:0] smp_in, hi_in, lo_in;
    if (k == 0) begin : g_head
      assign smp_in = raw;
    end else begin : g_body
      assign smp_in = smp[k-1];
    end
    if (k == WindowMax - 1) begin : g_tail
      assign hi_in = smp[k];
      assign lo_in = smp[k];
    end else begin : g_link
      assign hi_in = hi[k+1];
      assign lo_in = lo[k+1];
    end
    swm_cell #(
      .SampleWidth(SampleWidth),
      .LenWidth   (LenWidth),
      .Idx        (k)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .len_i (len),
      .smp_i (smp_in),
      .smp_o (smp[k]),
      .hi_i  (hi_in),
      .lo_i  (lo_in),
      .hi_o  (hi[k]),
      .lo_o  (lo[k])
    );
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the sliding window midpoint block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned RingDepth   = 256;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned CycleLimit  = 1500000;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  swm_pkg::in_item_t            in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  swm_pkg::out_item_t           out_data_o;
  logic                         cfg_we_i    = 1'b0;
  logic [swm_pkg::CfgWidth-1:0] cfg_wdata_i = '0;

  // Stimulus and expectations
  swm_pkg::in_item_t  pending_q[$];
  swm_pkg::out_item_t midpoint_q[$];
  int        error_count  = 0;
  int        cycle_count  = 0;
  logic      send_idle_on = 1'b1;
  logic      recv_idle_on = 1'b1;
  int        send_gap     = 0;
  int        recv_gap     = 0;
  int        hold_token   = 0;
  int        hold_seen    = 0;
  int        hold_left    = 0;

  // Predictor state, mirrors the block after reset
  logic signed [31:0]           ring [RingDepth];
  logic [8:0]                   fill_cnt    = '0;
  logic [7:0]                   wr_slot     = '0;
  logic [31:0]                  series_pos  = '0;
  logic [swm_pkg::CfgWidth-1:0] win_len_cfg = swm_pkg::LenReset;

  sliding_window_midpoint dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the window by one sample and queue the max-plus-min it yields
  function automatic void predict_midpoint(input swm_pkg::in_item_t it);
    swm_pkg::out_item_t res;
    int unsigned        span;
    logic [7:0]         slot;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] v;
    if (it.restart) begin
      fill_cnt   = '0;
      series_pos = '0;
      wr_slot    = '0;
    end
    ring[wr_slot] = it.sample;
    slot = wr_slot;
    wr_slot = wr_slot + 8'd1;
    if (fill_cnt < RingDepth) fill_cnt = fill_cnt + 9'd1;
    res.position = series_pos;
    series_pos = series_pos + 32'd1;
    span = (win_len_cfg == 0) ? 1 : (win_len_cfg > RingDepth) ? RingDepth : win_len_cfg;
    if (fill_cnt < span) return;
    hi = it.sample;
    lo = it.sample;
    for (int k = 1; k < span; k++) begin
      slot = slot - 8'd1;
      v = ring[slot];
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
    res.midpoint_x2 = {hi[31], hi} + {lo[31], lo};
    res.final_res   = it.last_sample;
    midpoint_q.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_midpoint(input swm_pkg::out_item_t got);
    swm_pkg::out_item_t want;
    if (midpoint_q.size() == 0) begin
      report_mismatch("unexpected result, position", 33'(got.position), '0);
      return;
    end
    want = midpoint_q.pop_front();
    if (got.midpoint_x2 !== want.midpoint_x2)
      report_mismatch("midpoint_x2", got.midpoint_x2, want.midpoint_x2);
    if (got.position !== want.position)
      report_mismatch("position", 33'(got.position), 33'(want.position));
    if (got.final_res !== want.final_res)
      report_mismatch("final_res", 33'(got.final_res), 33'(want.final_res));
  endtask

  function automatic void push_item(input logic [31:0] s, input logic rs, input logic ls);
    swm_pkg::in_item_t it;
    it.sample      = s;
    it.restart     = rs;
    it.last_sample = ls;
    pending_q.push_back(it);
  endfunction

  // Mix extremes and small values (to force ties) into full-range noise
  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Well-formed series: restart on the first sample, last on the final one
  function automatic void push_series(input int n);
    for (int i = 0; i < n; i++) push_item(draw_sample(), i == 0, i == n - 1);
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || midpoint_q.size() != 0) @(posedge clk_i);
  endtask

  // Write the window length once the block has gone quiet
  task automatic set_window(input logic [swm_pkg::CfgWidth-1:0] len);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    win_len_cfg = len;
  endtask

  // Sender: offer queued items, with a random gap after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_midpoint(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (pending_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_q.pop_front();
          send_gap   <= send_idle_on ? $urandom_range(0, 10) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each transfer, stall at random, and hold off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) check_midpoint(out_data_o);
      if (hold_token != hold_seen) begin
        hold_seen   <= hold_token;
        hold_left   <= LongHold;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i) begin
        recv_gap    <= recv_idle_on ? $urandom_range(0, 10) : 0;
        out_ready_i <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [swm_pkg::CfgWidth-1:0] span;
    int                           batch;
    int                           n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of the sample range over a window of three
    set_window(9'd3);
    push_item(32'h7FFF_FFFF, 1'b1, 1'b0);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'h0000_0000, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    repeat (3) push_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    repeat (3) push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'd5, 1'b0, 1'b1);
    // Last flag on an item with no result, then the series goes on
    push_item(32'd9, 1'b1, 1'b1);
    push_item(32'hFFFF_FFFD, 1'b0, 1'b0);
    push_item(32'd4, 1'b0, 1'b0);

    // Zero length acts as one
    set_window(9'd0);
    push_item(32'h7FFF_FFFF, 1'b1, 1'b1);
    push_item(32'h8000_0000, 1'b0, 1'b0);
    push_item(32'd1, 1'b0, 1'b0);
    // Change the length in the middle of a series
    set_window(9'd2);
    push_item(32'hFFFF_FFF9, 1'b0, 1'b1);
    set_window(9'd1);
    push_item(32'd0, 1'b1, 1'b0);

    // Full-depth window, then an oversized length that saturates
    set_window(9'd256);
    for (int i = 0; i < 270; i++) push_item(draw_sample(), i == 0, 1'b0);
    set_window(9'd511);
    for (int i = 0; i < 15; i++) push_item(draw_sample(), 1'b0, i == 14);
    set_window(9'd255);
    for (int i = 0; i < 10; i++) push_item(draw_sample(), 1'b0, i == 9);

    // Random phases over small windows
    for (int ph = 0; ph < 10; ph++) begin
      span = (ph % 3 == 0) ? 9'($urandom_range(17, 48)) : 9'($urandom_range(1, 16));
      set_window(span);
      send_idle_on <= (ph != 4);
      recv_idle_on <= (ph != 4 && ph != 7);
      // Receiver holds off while the sender keeps offering back to back
      if (ph == 4) hold_token <= hold_token + 1;
      batch = 0;
      while (batch < 50) begin
        if ($urandom_range(0, 9) == 0) begin
          push_item($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          batch++;
        end else begin
          n = $urandom_range(1, span + 12);
          push_series(n);
          batch += n;
        end
        // Pause the sender until every result is back
        if (ph == 6 && batch >= 25 && batch < 25 + n) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
